/* rtl/core/sscp_pkg.sv */
// Shared types for the segment closest-point pipeline.
`default_nettype none

package sscp_pkg;

    // Where an unclamped fixed-point quotient falls against the unit range
    typedef struct packed {
        logic below_zero;   // quotient is negative with a magnitude of at least one LSB
        logic above_one;    // quotient exceeds one
    } div_flag_t;

endpackage

`default_nettype wire

/* rtl/core/sscp_mul.sv */
// Two-stage signed multiplier built from four half-width partial products.
`default_nettype none

module sscp_mul #(
    parameter int W = 52
) (
    input  wire                   aclk,
    input  wire                   en_i,
    input  wire signed [W-1:0]    a_i,
    input  wire signed [W-1:0]    b_i,
    output logic signed [2*W-1:0] p_o
);

    localparam int H  = W / 2;
    localparam int HW = W - H;
    localparam int TW = 2 * W;

    logic signed [HW-1:0]     ah, bh;
    logic        [H-1:0]      al, bl;
    logic signed [2*HW-1:0]   hh_next, hh_reg;
    logic signed [HW+H:0]     hl_next, hl_reg, lh_next, lh_reg;
    logic        [2*H-1:0]    ll_next, ll_reg;
    logic signed [TW-1:0]     p_next;

    always_comb begin
        ah      = a_i[W-1:H];
        bh      = b_i[W-1:H];
        al      = a_i[H-1:0];
        bl      = b_i[H-1:0];
        hh_next = ah * bh;
        hl_next = ah * $signed({1'b0, bl});
        lh_next = $signed({1'b0, al}) * bh;
        ll_next = al * bl;
    end

    always_ff @(posedge aclk) begin
        if (en_i) begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
    end

    // recombine the partial products at their weights
    assign p_next = (TW'(hh_reg) <<< (2 * H)) + (TW'(hl_reg) <<< H) + (TW'(lh_reg) <<< H)
                  + TW'($signed({1'b0, ll_reg}));

    always_ff @(posedge aclk) begin
        if (en_i) begin
            p_o <= p_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/sscp_div.sv */
// Pipelined restoring divider giving a fixed-point quotient clamped to [0, 1].
`default_nettype none

module sscp_div #(
    parameter int NW = 53,
    parameter int FB = 16
) (
    input  wire                  aclk,
    input  wire                  en_i,
    input  wire signed [NW-1:0]  num_i,
    input  wire signed [NW-1:0]  den_i,
    output logic [FB:0]          quo_o,
    output sscp_pkg::div_flag_t  flag_o
);

    typedef struct packed {
        logic                zero;
        logic                one;
        sscp_pkg::div_flag_t flag;
    } ctl_t;

    logic [NW-1:0] un, ud;
    logic          sd, ge;
    ctl_t          ctl_next;

    logic [NW-1:0] rem_reg [0:FB-1];
    logic [NW-1:0] den_reg [0:FB-1];
    logic [FB-1:0] quo_reg [1:FB];
    ctl_t          ctl_reg [0:FB];

    always_comb begin
        un = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
        ud = den_i[NW-1] ? NW'(-den_i) : NW'(den_i);
        sd = num_i[NW-1] ^ den_i[NW-1];
        ge = un >= ud;
        ctl_next.zero = sd;
        ctl_next.one  = !sd && ge;
        ctl_next.flag.below_zero = sd && ({un, {FB{1'b0}}} >= (NW+FB)'(ud));
        ctl_next.flag.above_one  = !sd && ((NW+FB+1)'({un, {FB{1'b0}}})
                                   >= (NW+FB+1)'({ud, {FB{1'b0}}}) + (NW+FB+1)'(ud));
    end

    // a numerator at or above the divisor saturates at one (zero if the signs differ); start from zero then
    always_ff @(posedge aclk) begin
        if (en_i) begin
            rem_reg[0] <= ge ? '0 : un;
            den_reg[0] <= ud;
            ctl_reg[0] <= ctl_next;
        end
    end

    for (genvar j = 1; j <= FB; j++) begin : g_step
        logic [NW+1:0] diff;
        logic          qbit;

        assign diff = {1'b0, rem_reg[j-1], 1'b0} - {2'b00, den_reg[j-1]};
        assign qbit = ~diff[NW+1];

        if (j == 1) begin : g_first
            always_ff @(posedge aclk) begin
                if (en_i) begin
                    quo_reg[j] <= FB'(qbit);
                end
            end
        end else begin : g_next
            always_ff @(posedge aclk) begin
                if (en_i) begin
                    quo_reg[j] <= {quo_reg[j-1][FB-2:0], qbit};
                end
            end
        end

        if (j < FB) begin : g_rem
            always_ff @(posedge aclk) begin
                if (en_i) begin
                    rem_reg[j] <= qbit ? diff[NW-1:0] : {rem_reg[j-1][NW-2:0], 1'b0};
                    den_reg[j] <= den_reg[j-1];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en_i) begin
                ctl_reg[j] <= ctl_reg[j-1];
            end
        end
    end

    always_comb begin
        if (ctl_reg[FB].zero) begin
            quo_o = '0;
        end else if (ctl_reg[FB].one) begin
            quo_o = (FB+1)'(1) << FB;
        end else begin
            quo_o = {1'b0, quo_reg[FB]};
        end
        flag_o = ctl_reg[FB].flag;
    end

endmodule

`default_nettype wire

/* rtl/core/segment_segment_closest_points.sv */
// Closest points between two 3D segments: pipelined top level.
// Usage:
//   Input channel s_*: one request carries both segments, twelve signed
//   coordinates of COORD_BITS with FRAC_BITS fraction bits. Result channel m_*:
//   the closest point on each segment, saturated to the coordinate range.
//   One request is taken every cycle unless the receiver stalls. The depth
//   comes from two chained dividers, each resolving one quotient bit per
//   stage: the first finds the first-segment parameter, the second the
//   second-segment one. Candidate parameters for the clamped cases are
//   divided alongside the first.
//   Reset clears all valid bits; data registers keep whatever they held.
//   When the receiver stalls the whole pipeline holds, s_tready drops with it,
//   and nothing is dropped or repeated.
`default_nettype none

module segment_segment_closest_points #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire  aclk,
    input  wire  aresetn,
    input  wire  s_tvalid,
    output logic s_tready,
    // first_start_x/y/z, first_end_x/y/z, second_start_x/y/z, second_end_x/y/z
    input  wire  [((12*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  wire  m_tready,
    // near_first_x/y/z, near_second_x/y/z
    output logic [((6*COORD_BITS+7)/8)*8-1:0]  m_tdata
);

    localparam int C    = COORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DW   = C + 1;
    localparam int SHW  = 2 * DW - F;
    localparam int DOTW = SHW + 2;
    localparam int PRW  = 2 * DOTW - F;
    localparam int NUMW = PRW + 1;
    localparam int NTW  = DOTW + 2;
    localparam int QW   = F + 1;
    localparam int L    = F + 1;
    localparam int N    = 10 + 2 * L;
    localparam int SEL  = 8 + 2 * L;
    localparam int OW   = C + 3;
    localparam logic [QW-1:0] ONE = QW'(1) << F;

    typedef struct packed {
        logic [2:0][C-1:0]  p0;
        logic [2:0][C-1:0]  q0;
        logic [2:0][DW-1:0] d1;
        logic [2:0][DW-1:0] d2;
        logic [DOTW-1:0]    a;
        logic [DOTW-1:0]    b;
        logic [DOTW-1:0]    e;
        logic [DOTW-1:0]    f;
        logic               a_zero;
        logic               e_zero;
        logic [QW-1:0]      slo;
        logic [QW-1:0]      shi;
        logic [QW-1:0]      s0;
    } car_t;

    function automatic logic signed [SHW-1:0] fx_dd(input logic signed [DW-1:0] x,
                                                    input logic signed [DW-1:0] y);
        logic signed [2*DW-1:0] m;
        m = x * y;
        return m[2*DW-1:F];
    endfunction

    logic en;
    logic vld_reg [1:N];
    car_t car_reg [1:N-1];
    car_t car_next [1:N-1];

    logic signed [C-1:0]  in_p0 [3], in_p1 [3], in_q0 [3], in_q1 [3];
    logic signed [DW-1:0] r_next [3];
    logic signed [DW-1:0] r1_reg [3];

    logic signed [SHW-1:0] aa_reg [3], ee_reg [3], ff_reg [3], cc_reg [3], bb_reg [3];
    logic signed [DOTW-1:0] a3_reg, b3_reg, c3_reg, e3_reg, f3_reg;

    logic signed [DOTW:0] nlo_reg, nhi_reg, lo_den;
    logic [QW-1:0] slo_q, shi_q, s0_q, t_q;
    sscp_pkg::div_flag_t t_flag;

    logic signed [2*DOTW-1:0] ae_p, bb_p, bf_p, ce_p;
    logic signed [NUMW-1:0]   num_next, den_next, num1_reg, den1_reg;

    logic signed [DOTW+QW:0] bs_m;
    logic signed [NTW-1:0]   bs_reg, nt_reg, t_den;

    logic [QW-1:0]         s_sel, t_sel;
    logic signed [OW-1:0]  off1_reg [3], off2_reg [3];
    logic [C-1:0]          out_reg [6];

    assign en       = !vld_reg[N] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[N];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= N; k++) vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[1] <= s_tvalid;
            for (int k = 2; k <= N; k++) vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 1: unpack, direction vectors and start offset
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_p0[i]  = s_tdata[i*C +: C];
            in_p1[i]  = s_tdata[(3+i)*C +: C];
            in_q0[i]  = s_tdata[(6+i)*C +: C];
            in_q1[i]  = s_tdata[(9+i)*C +: C];
            r_next[i] = DW'(in_p0[i]) - DW'(in_q0[i]);
        end
    end

    // carry line: fields join the item at the stage that produces them
    always_comb begin
        car_next[1] = '0;
        for (int i = 0; i < 3; i++) begin
            car_next[1].p0[i] = in_p0[i];
            car_next[1].q0[i] = in_q0[i];
            car_next[1].d1[i] = DW'(in_p1[i]) - DW'(in_p0[i]);
            car_next[1].d2[i] = DW'(in_q1[i]) - DW'(in_q0[i]);
        end
        for (int k = 2; k <= N-1; k++) car_next[k] = car_reg[k-1];
        car_next[4].a      = a3_reg;
        car_next[4].b      = b3_reg;
        car_next[4].e      = e3_reg;
        car_next[4].f      = f3_reg;
        car_next[4].a_zero = (a3_reg == '0);
        car_next[4].e_zero = (e3_reg == '0);
        car_next[5+L].slo  = slo_q;
        car_next[5+L].shi  = shi_q;
        car_next[7+L].s0   = s0_q;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 1; k <= N-1; k++) car_reg[k] <= car_next[k];
            for (int i = 0; i < 3; i++) r1_reg[i] <= r_next[i];
        end
    end

    // stage 2: fifteen coordinate products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                aa_reg[i] <= fx_dd($signed(car_reg[1].d1[i]), $signed(car_reg[1].d1[i]));
                ee_reg[i] <= fx_dd($signed(car_reg[1].d2[i]), $signed(car_reg[1].d2[i]));
                ff_reg[i] <= fx_dd($signed(car_reg[1].d2[i]), r1_reg[i]);
                cc_reg[i] <= fx_dd($signed(car_reg[1].d1[i]), r1_reg[i]);
                bb_reg[i] <= fx_dd($signed(car_reg[1].d1[i]), $signed(car_reg[1].d2[i]));
            end
        end
    end

    // stage 3: dot products
    always_ff @(posedge aclk) begin
        if (en) begin
            a3_reg <= DOTW'(aa_reg[0]) + DOTW'(aa_reg[1]) + DOTW'(aa_reg[2]);
            e3_reg <= DOTW'(ee_reg[0]) + DOTW'(ee_reg[1]) + DOTW'(ee_reg[2]);
            f3_reg <= DOTW'(ff_reg[0]) + DOTW'(ff_reg[1]) + DOTW'(ff_reg[2]);
            c3_reg <= DOTW'(cc_reg[0]) + DOTW'(cc_reg[1]) + DOTW'(cc_reg[2]);
            b3_reg <= DOTW'(bb_reg[0]) + DOTW'(bb_reg[1]) + DOTW'(bb_reg[2]);
        end
    end

    // stage 4: numerators of the clamped-case parameters
    always_ff @(posedge aclk) begin
        if (en) begin
            nlo_reg <= -(DOTW+1)'(c3_reg);
            nhi_reg <= (DOTW+1)'(b3_reg) - (DOTW+1)'(c3_reg);
        end
    end

    sscp_mul #(.W(DOTW)) u_mul_ae (
        .aclk(aclk), .en_i(en), .a_i(a3_reg), .b_i(e3_reg), .p_o(ae_p));
    sscp_mul #(.W(DOTW)) u_mul_bb (
        .aclk(aclk), .en_i(en), .a_i(b3_reg), .b_i(b3_reg), .p_o(bb_p));
    sscp_mul #(.W(DOTW)) u_mul_bf (
        .aclk(aclk), .en_i(en), .a_i(b3_reg), .b_i(f3_reg), .p_o(bf_p));
    sscp_mul #(.W(DOTW)) u_mul_ce (
        .aclk(aclk), .en_i(en), .a_i(c3_reg), .b_i(e3_reg), .p_o(ce_p));

    assign lo_den = (DOTW+1)'($signed(car_reg[4].a));

    sscp_div #(.NW(DOTW+1), .FB(F)) u_div_lo (
        .aclk(aclk), .en_i(en), .num_i(nlo_reg), .den_i(lo_den),
        .quo_o(slo_q), .flag_o());
    sscp_div #(.NW(DOTW+1), .FB(F)) u_div_hi (
        .aclk(aclk), .en_i(en), .num_i(nhi_reg), .den_i(lo_den),
        .quo_o(shi_q), .flag_o());

    // stage 6: general-case numerator and denominator; parallel or degenerate gives zero
    always_comb begin
        num_next = NUMW'($signed(bf_p[2*DOTW-1:F])) - NUMW'($signed(ce_p[2*DOTW-1:F]));
        den_next = NUMW'($signed(ae_p[2*DOTW-1:F])) - NUMW'($signed(bb_p[2*DOTW-1:F]));
        if (car_reg[5].a_zero || den_next == '0) begin
            num_next = '0;
            den_next = NUMW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num1_reg <= num_next;
            den1_reg <= den_next;
        end
    end

    sscp_div #(.NW(NUMW), .FB(F)) u_div_s (
        .aclk(aclk), .en_i(en), .num_i(num1_reg), .den_i(den1_reg),
        .quo_o(s0_q), .flag_o());

    // second parameter numerator: b*s + f
    assign bs_m = $signed(car_reg[6+L].b) * $signed({1'b0, s0_q});

    always_ff @(posedge aclk) begin
        if (en) begin
            bs_reg <= bs_m[DOTW+QW:F];
            nt_reg <= bs_reg + NTW'($signed(car_reg[7+L].f));
        end
    end

    assign t_den = NTW'($signed(car_reg[8+L].e));

    sscp_div #(.NW(NTW), .FB(F)) u_div_t (
        .aclk(aclk), .en_i(en), .num_i(nt_reg), .den_i(t_den),
        .quo_o(t_q), .flag_o(t_flag));

    // pick the final parameters, then scale the directions
    always_comb begin
        t_sel = car_reg[SEL].e_zero ? '0 : t_q;
        if (car_reg[SEL].a_zero) begin
            s_sel = '0;
        end else if (car_reg[SEL].e_zero || t_flag.below_zero) begin
            s_sel = car_reg[SEL].slo;
        end else if (t_flag.above_one) begin
            s_sel = car_reg[SEL].shi;
        end else begin
            s_sel = car_reg[SEL].s0;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [DW+QW:0] m1, m2;
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                m1 = $signed(car_reg[SEL].d1[i]) * $signed({1'b0, s_sel});
                m2 = $signed(car_reg[SEL].d2[i]) * $signed({1'b0, t_sel});
                off1_reg[i] <= m1[DW+QW:F];
                off2_reg[i] <= m2[DW+QW:F];
            end
        end
    end

    // last stage: add the start points and saturate
    always_ff @(posedge aclk) begin
        logic signed [OW-1:0] sum;
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                if (i < 3) begin
                    sum = OW'($signed(car_reg[N-1].p0[i])) + off1_reg[i];
                end else begin
                    sum = OW'($signed(car_reg[N-1].q0[i-3])) + off2_reg[i-3];
                end
                if (sum[OW-1:C-1] == '0 || sum[OW-1:C-1] == '1) begin
                    out_reg[i] <= sum[C-1:0];
                end else if (sum[OW-1]) begin
                    out_reg[i] <= {1'b1, {(C-1){1'b0}}};
                end else begin
                    out_reg[i] <= {1'b0, {(C-1){1'b1}}};
                end
            end
        end
    end

    always_comb begin
        m_tdata = '0;
        for (int i = 0; i < 6; i++) m_tdata[i*C +: C] = out_reg[i];
    end

    a_param_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[SEL] |-> (s_sel <= ONE && t_sel <= ONE))
        else $error("segment parameter outside the unit range");

    a_first_degenerate: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[SEL] && car_reg[SEL].a_zero) |-> (s_sel == '0))
        else $error("zero-length first segment moved off its start point");

    a_second_degenerate: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[SEL] && car_reg[SEL].e_zero) |-> (t_sel == '0))
        else $error("zero-length second segment moved off its start point");

endmodule

`default_nettype wire
